>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define PBSA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbsa assertion failed");

// Next-cycle implication
`define PBSA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbsa assertion failed");

`endif

>>> rtl/core/pbsa_pkg.sv
// ---------------------------------------------------------------------------
// pbsa_pkg
// Shared constants and types of the pixel / beam strip overlap block.
// ---------------------------------------------------------------------------
package pbsa_pkg;

   // Restoring divider steps; quotients always fit 16 bits
   localparam int DIV_STEPS = 16;
   // Register stages inside one line unit: 5 front + divider + 1 finish
   localparam int LINE_LAT  = 5 + DIV_STEPS + 1;

   localparam logic [15:0] HALF_Q16 = 16'h8000;
   localparam logic [16:0] ONE_Q16  = 17'h10000;

   // Per-line result handed to the combine stage
   typedef struct packed {
      logic [15:0] frac;   // half-pixel fraction, Q0.16, at most one half
      logic        pos;    // signed distance strictly positive
   } line_res_type;

endpackage

>>> rtl/core/pbsa_line.sv
// ---------------------------------------------------------------------------
// pbsa_line
// Pipelined half-pixel area fraction for one boundary line, with a
// 16-step restoring divider shared by the linear and corner cases.
// ---------------------------------------------------------------------------
module pbsa_line
   import pbsa_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] line_a,
   input  logic signed [15:0] line_b,
   input  logic signed [27:0] line_c,
   input  logic signed [27:0] pixel_x,
   input  logic signed [27:0] pixel_y,
   output line_res_type       result
);

   // Stage 1: products and coefficient magnitudes
   logic signed [43:0] ax_ff, by_ff;
   logic signed [41:0] cs_ff;
   logic        [15:0] aa_ff, bb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= 44'(line_a) * 44'(pixel_x);
         by_ff <= 44'(line_b) * 44'(pixel_y);
         cs_ff <= 42'(line_c) <<< 14;
         aa_ff <= line_a[15] ? (~line_a + 16'd1) : line_a;
         bb_ff <= line_b[15] ? (~line_b + 16'd1) : line_b;
      end
   end

   // Stage 2: signed distance in Q.30, bounds, max and product of magnitudes
   logic signed [45:0] t_ff;
   logic        [31:0] dmax_ff, d0_ff, ab_ff;
   logic        [15:0] m_ff;
   logic        [16:0] sum_in;
   logic        [15:0] diff_in;

   assign sum_in  = {1'b0, aa_ff} + {1'b0, bb_ff};
   assign diff_in = (aa_ff >= bb_ff) ? (aa_ff - bb_ff) : (bb_ff - aa_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= 46'(cs_ff) - 46'(ax_ff) - 46'(by_ff);
         dmax_ff <= {sum_in, 15'd0};
         d0_ff   <= {1'b0, diff_in, 15'd0};
         ab_ff   <= 32'(aa_ff) * 32'(bb_ff);
         m_ff    <= (aa_ff >= bb_ff) ? aa_ff : bb_ff;
      end
   end

   // Stage 3: magnitude, sign and case selection
   logic [45:0] d_in;
   logic [31:0] e3_ff, dl3_ff, ab3_ff;
   logic [15:0] m3_ff;
   logic        half3_ff, lin3_ff, pos3_ff;

   assign d_in = t_ff[45] ? (~t_ff + 46'd1) : t_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         half3_ff <= d_in >= {14'd0, dmax_ff};
         lin3_ff  <= d_in <= {14'd0, d0_ff};
         pos3_ff  <= !t_ff[45] && (t_ff != '0);
         e3_ff    <= dmax_ff - d_in[31:0];
         dl3_ff   <= d_in[31:0];
         ab3_ff   <= ab_ff;
         m3_ff    <= m_ff;
      end
   end

   // Stage 4: square of the distance to the corner
   logic [63:0] ee4_ff;
   logic [31:0] dl4_ff, ab4_ff;
   logic [15:0] m4_ff;
   logic        half4_ff, lin4_ff, pos4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ee4_ff   <= 64'(e3_ff) * 64'(e3_ff);
         dl4_ff   <= dl3_ff;
         ab4_ff   <= ab3_ff;
         m4_ff    <= m3_ff;
         half4_ff <= half3_ff;
         lin4_ff  <= lin3_ff;
         pos4_ff  <= pos3_ff;
      end
   end

   // Stage 5: rounded numerator and divisor, loaded into divider stage 0
   logic [48:0] rem_ff  [DIV_STEPS+1];
   logic [48:0] den_ff  [DIV_STEPS+1];
   logic [15:0] q_ff    [DIV_STEPS+1];
   logic [15:0] lo_ff   [DIV_STEPS+1];
   logic        half_ff [DIV_STEPS+1];
   logic        lin_ff  [DIV_STEPS+1];
   logic        pos_ff  [DIV_STEPS+1];
   logic [62:0] num_in;

   assign num_in = lin4_ff ? (63'(dl4_ff) + 63'(m4_ff >> 1))
                           : (ee4_ff[62:0] + {15'd0, ab4_ff, 16'd0});

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= {2'b00, num_in[62:16]};
         lo_ff[0]   <= num_in[15:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= lin4_ff ? {33'd0, m4_ff} : {ab4_ff, 17'd0};
         half_ff[0] <= half4_ff;
         lin_ff[0]  <= lin4_ff;
         pos_ff[0]  <= pos4_ff;
      end
   end

   // Divider: one quotient bit per stage, remainder kept below the divisor
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [49:0] trial;
      logic        ge;

      assign trial = {rem_ff[k], lo_ff[k][15]};
      assign ge    = trial >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? 49'(trial - {1'b0, den_ff[k]}) : trial[48:0];
            q_ff[k+1]    <= {q_ff[k][14:0], ge};
            lo_ff[k+1]   <= {lo_ff[k][14:0], 1'b0};
            den_ff[k+1]  <= den_ff[k];
            half_ff[k+1] <= half_ff[k];
            lin_ff[k+1]  <= lin_ff[k];
            pos_ff[k+1]  <= pos_ff[k];
         end
      end
   end

   // Finish: pick case and clamp to one half
   logic [15:0] qf;
   logic [15:0] frac_in;
   line_res_type res_ff;

   assign qf = q_ff[DIV_STEPS];

   always_comb begin
      if (half_ff[DIV_STEPS]) begin
         frac_in = HALF_Q16;
      end else if (lin_ff[DIV_STEPS]) begin
         frac_in = (qf > HALF_Q16) ? HALF_Q16 : qf;
      end else begin
         frac_in = (qf >= HALF_Q16) ? 16'd0 : (HALF_Q16 - qf);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.frac <= frac_in;
         res_ff.pos  <= pos_ff[DIV_STEPS];
      end
   end

   assign result = res_ff;

endmodule

>>> rtl/core/pixel_beam_strip_area_top.sv
// ---------------------------------------------------------------------------
// pixel_beam_strip_area_top
// Overlap area of a unit pixel with a beam strip bounded by two lines.
// ---------------------------------------------------------------------------
//  channel   direction  ports        payload
//  request   in         req_t*       two lines (a, b, c) and pixel center
//  response  out        rsp_t*       overlap area, Q1.16
//
//  One transaction accepted per clock while the response is not stalled; the
//  result passes the 22 stages of each line unit, mostly the 16-step divider,
//  then the combinational combine and the output register.
//  Reset clears the valid bits of all stages and the output register.
//  A stalled response freezes the whole pipeline; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_beam_strip_area_top
   import pbsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a1[15:0] b1[31:16] c1[59:32] a2[75:60] b2[91:76] c2[119:92]
   // x[147:120] y[175:148]
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // overlap_area[16:0], zeros above
   output logic [23:0]  rsp_tdata
);

   logic en;
   line_res_type res1, res2;

   // Pipeline advances when the output slot is free or being taken
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   pbsa_line u_line1 (
      .clock   (clock),
      .en      (en),
      .line_a  ($signed(req_tdata[15:0])),
      .line_b  ($signed(req_tdata[31:16])),
      .line_c  ($signed(req_tdata[59:32])),
      .pixel_x ($signed(req_tdata[147:120])),
      .pixel_y ($signed(req_tdata[175:148])),
      .result  (res1)
   );

   pbsa_line u_line2 (
      .clock   (clock),
      .en      (en),
      .line_a  ($signed(req_tdata[75:60])),
      .line_b  ($signed(req_tdata[91:76])),
      .line_c  ($signed(req_tdata[119:92])),
      .pixel_x ($signed(req_tdata[147:120])),
      .pixel_y ($signed(req_tdata[175:148])),
      .result  (res2)
   );

   // Valid bits traveling alongside the line units
   logic [LINE_LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LINE_LAT-2:0], req_tvalid};
      end
   end

   // Combine the two half fractions
   logic [16:0] area_in;
   logic [16:0] sum_in;

   always_comb begin
      if (res1.pos == res2.pos) begin
         sum_in = (res1.frac >= res2.frac) ? {1'b0, res1.frac - res2.frac}
                                           : {1'b0, res2.frac - res1.frac};
      end else begin
         sum_in = {1'b0, res1.frac} + {1'b0, res2.frac};
      end
      area_in = (sum_in > ONE_Q16) ? ONE_Q16 : sum_in;
   end

   // Output register
   logic        rsp_valid_ff;
   logic [16:0] area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[LINE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         area_ff <= area_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, area_ff};

   // Checks
   `PBSA_ASSERT_IMP(a_frac1_half, vld_ff[LINE_LAT-1], res1.frac <= HALF_Q16)
   `PBSA_ASSERT_IMP(a_frac2_half, vld_ff[LINE_LAT-1], res2.frac <= HALF_Q16)
   `PBSA_ASSERT_IMP(a_area_one, rsp_tvalid, area_ff <= ONE_Q16)
   `PBSA_ASSERT_NXT(a_last_to_out, vld_ff[LINE_LAT-1] && en, rsp_tvalid)

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for pixel_beam_strip_area_top: pixel and two-line
// transactions go in, each predicted overlap area is queued and compared with
// the response stream in order, under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb;
   import pbsa_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;

   typedef struct {
      logic signed [15:0] a1, b1;
      logic signed [27:0] c1;
      logic signed [15:0] a2, b2;
      logic signed [27:0] c2;
      logic signed [27:0] px, py;
   } strip_pixel_type;

   logic [16:0] area_q[$];
   int          errors = 0;
   bit          sink_hold = 0;
   int          sink_stall_pct = 30;
   int          gap_pct = 20;

   pixel_beam_strip_area_top dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // half-pixel fraction of one line, Q0.16; sets pos when distance > 0
   function automatic logic [15:0] half_frac(input logic signed [15:0] a,
         input logic signed [15:0] b, input logic signed [27:0] c,
         input logic signed [27:0] x, input logic signed [27:0] y,
         output logic pos);
      longint t;
      longint unsigned d, aa, bb, dmax, d0, m, e, den, q, f;
      t = longint'(c) * 16384 - longint'(a) * longint'(x) - longint'(b) * longint'(y);
      pos = t > 0;
      d = t < 0 ? -t : t;
      aa = a < 0 ? -longint'(a) : a;
      bb = b < 0 ? -longint'(b) : b;
      dmax = (aa + bb) << 15;
      d0 = (aa > bb ? aa - bb : bb - aa) << 15;
      if (d >= dmax) return HALF_Q16;
      if (d <= d0) begin
         m = aa > bb ? aa : bb;
         if (m == 0) return HALF_Q16;
         f = (d + m / 2) / m;
      end else begin
         e = dmax - d;
         den = (aa * bb) << 17;
         if (den == 0) return HALF_Q16;
         q = (e * e + den / 2) / den;
         f = q >= 32768 ? 0 : 32768 - q;
      end
      if (f > 32768) f = 32768;
      return f[15:0];
   endfunction

   function automatic logic [16:0] strip_area(input strip_pixel_type s);
      logic p1, p2;
      logic [16:0] f1, f2, r;
      f1 = half_frac(s.a1, s.b1, s.c1, s.px, s.py, p1);
      f2 = half_frac(s.a2, s.b2, s.c2, s.px, s.py, p2);
      if (p1 == p2) r = f1 >= f2 ? f1 - f2 : f2 - f1;
      else r = f1 + f2;
      return r > ONE_Q16 ? ONE_Q16 : r;
   endfunction

   // one request transaction; holds valid across back-to-back items
   task automatic send_item(input strip_pixel_type s);
      req_tvalid <= 1'b1;
      req_tdata <= {s.py, s.px, s.c2, s.b2, s.a2, s.c1, s.b1, s.a1};
      do @(posedge clock); while (!req_tready);
      area_q.push_back(strip_area(s));
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic signed [15:0] rnd_coef();
      case ($urandom_range(7))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'sh8000;
         4: return $signed(16'($urandom_range(0, 32)) - 16'sd16);
         default: return $signed(16'($urandom_range(0, 32768)) - 16'sd16384);
      endcase
   endfunction

   function automatic logic signed [27:0] rnd_q16();
      return $signed(28'($urandom));
   endfunction

   // random geometry; mostly pixels near the lines so all cases are hit
   function automatic strip_pixel_type rnd_item();
      strip_pixel_type s;
      longint t;
      s.a1 = rnd_coef(); s.b1 = rnd_coef(); s.a2 = rnd_coef(); s.b2 = rnd_coef();
      if ($urandom_range(9) < 2) begin
         s.px = rnd_q16(); s.py = rnd_q16(); s.c1 = rnd_q16(); s.c2 = rnd_q16();
      end else begin
         s.px = $signed(28'($urandom_range(0, 1 << 22))) - 28'sd2097152;
         s.py = $signed(28'($urandom_range(0, 1 << 22))) - 28'sd2097152;
         // c chosen so the line passes within about two pixels of the center
         t = (longint'(s.a1) * s.px + longint'(s.b1) * s.py) / 16384
             + $signed(32'($urandom_range(0, 262144))) - 131072;
         s.c1 = t[27:0];
         t = (longint'(s.a2) * s.px + longint'(s.b2) * s.py) / 16384
             + $signed(32'($urandom_range(0, 262144))) - 131072;
         s.c2 = t[27:0];
      end
      return s;
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (area_q.size() == 0) begin
            $display("%0t: unexpected area, expected none, actual %0d", $time,
                     rsp_tdata[16:0]);
            errors++;
         end else begin
            if (rsp_tdata[16:0] !== area_q[0] || rsp_tdata[23:17] !== 7'd0) begin
               $display("%0t: area mismatch, expected %0d, actual %0d", $time,
                        area_q[0], rsp_tdata);
               errors++;
            end
            void'(area_q.pop_front());
         end
      end
   end

   // sink stall pattern
   always @(posedge clock)
      rsp_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);

   task automatic test_directed();
      strip_pixel_type s;
      logic signed [27:0] xs[4] = '{28'sh7FFFFFF, -28'sh8000000, 28'sd0, 28'sd65536};
      for (int i = 0; i < 4; i++) begin
         // both coefficients zero, then extreme coefficients and coordinates
         s = '{16'sd0, 16'sd0, xs[i], 16'sd16384, -16'sd16384, xs[3-i], xs[i], xs[3-i]};
         send_item(s);
         s = '{16'sh8000, 16'sh8000, xs[i], 16'sh7FFF, 16'sd0, -xs[i], xs[3-i], xs[i]};
         send_item(s);
      end
      // pixel center on the line: zero distance counts as negative
      send_item('{16'sd16384, 16'sd0, 28'sd0, 16'sd16384, 16'sd0, 28'sd0, 28'sd0, 28'sd0});
      // one coefficient zero, linear case; opposite signs
      send_item('{16'sd16384, 16'sd0, 28'sd16384, -16'sd16384, 16'sd0, 28'sd16384,
                  28'sd0, 28'sd0});
      // diagonal lines: corner case, and inside the linear band
      send_item('{16'sd16384, 16'sd16384, 28'sd20000, 16'sd16384, 16'sd8192, -28'sd9000,
                  28'sd0, 28'sd0});
      send_item('{16'sd16384, 16'sd4096, 28'sd1000, -16'sd4096, 16'sd16384, 28'sd50000,
                  28'sd0, 28'sd0});
      // beyond dmax on both sides
      send_item('{16'sd1, 16'sd1, 28'sd5000000, 16'sd1, -16'sd1, -28'sd5000000,
                  28'sd0, 28'sd0});
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         gap_pct = (i / 200) % 2 ? 0 : 25;
         sink_stall_pct = (i / 300) % 2 ? 0 : 35;
         send_item(rnd_item());
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic test_backpressure();
      fork
         begin
            sink_hold = 1;
            repeat (80) @(posedge clock);
            sink_hold = 0;
         end
         begin
            gap_pct = 0;
            for (int i = 0; i < 60; i++) send_item(rnd_item());
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      join
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(1400);
      wait (area_q.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pbsa_pkg.sv
rtl/core/pbsa_line.sv
rtl/core/pixel_beam_strip_area_top.sv
verif/tb.sv
